>>> src/global_average_pool_core_defines.svh
// Assertion macros shared by the checker files of the pooling core.
// Relies on signals named clk and arst_n in the scope of each use.
`ifndef GLOBAL_AVERAGE_POOL_CORE_DEFINES_SVH
`define GLOBAL_AVERAGE_POOL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GAP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pooling core check failed");

// Next-cycle implication, disabled while in reset
`define GAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pooling core check failed");

`endif

>>> src/gap_pkg.sv
// Shared constants for the global average pooling core.
// Used by the core, its checker and the testbench; depends on nothing.
package gap_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_AREA      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_RECIPROCAL = 2'd2;

	localparam int CH_COUNT_W = 11;
	localparam int AREA_CFG_W = 17;
	localparam int RECIP_W    = 17;

	localparam logic [CH_COUNT_W-1:0] CH_COUNT_RST = 11'd1;
	localparam logic [AREA_CFG_W-1:0] AREA_RST     = 17'd1;
	localparam logic [RECIP_W-1:0]    RECIP_RST    = 17'd65536;

	// datapath
	localparam int SUM_W       = 32;
	localparam int IDX_W       = 10;
	localparam int ROUND_SHIFT = 16;

endpackage

>>> src/gap_out_buf.sv
// Two-entry output buffer: a result register plus a skid entry.
// Generic payload vector; no package dependency.
module gap_out_buf #(
	parameter int DATA_W = 27
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] out_data
);

	logic [1:0]        cnt_q;
	logic [DATA_W-1:0] head_q;
	logic [DATA_W-1:0] skid_q;
	logic              pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && !push) begin
			head_q <= skid_q;
		end else if (pop && push) begin
			// push only happens below two entries, so the head is the one leaving
			head_q <= push_data;
		end
	end

endmodule

>>> src/global_average_pool_core.sv
// Global average pooling core, NHWC stream, one sample per item.
// Throughput: one item per cycle while the input is not stalled; the accumulator memory is read at accept
// and written back from stage 1, with the write forwarded when the next item hits the same channel.
// A completed channel's result passes the stage 1, 2 and 3 registers, then enters the output buffer.
// Input stalls only while the two-entry output buffer is full.
// Reset (arst_n, async): clears positions and pipeline, loads register defaults; sums not cleared.
module global_average_pool_core #(
	parameter int MAX_CHANNELS = 1024,
	parameter int MAX_AREA     = 65536,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gap_pkg::CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	// result items
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]  average,
	output logic [gap_pkg::IDX_W-1:0]      channel_index,
	output logic                           last_channel
);

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);
	localparam int PX_W   = (MAX_AREA > 1) ? $clog2(MAX_AREA) : 1;
	localparam int AREA_W = $clog2(MAX_AREA + 1);
	localparam int SUM_W  = gap_pkg::SUM_W;
	localparam int PROD_W = gap_pkg::SUM_W + gap_pkg::RECIP_W;
	localparam int RND_W  = PROD_W - gap_pkg::ROUND_SHIFT;
	localparam int DATA_W = SAMPLE_BITS + gap_pkg::IDX_W + 1;

	localparam logic signed [RND_W-1:0] SAT_HI =
		RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_LO =
		RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (gap_pkg::ROUND_SHIFT - 1));

	// configuration registers
	logic [gap_pkg::CH_COUNT_W-1:0] ch_count_q;
	logic [gap_pkg::AREA_CFG_W-1:0] area_q;
	logic [gap_pkg::RECIP_W-1:0]    recip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_count_q <= gap_pkg::CH_COUNT_RST;
			area_q     <= gap_pkg::AREA_RST;
			recip_q    <= gap_pkg::RECIP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gap_pkg::REG_CHANNEL_COUNT:   ch_count_q <= cfg_data[gap_pkg::CH_COUNT_W-1:0];
				gap_pkg::REG_IMAGE_AREA:      area_q     <= cfg_data[gap_pkg::AREA_CFG_W-1:0];
				gap_pkg::REG_AREA_RECIPROCAL: recip_q    <= cfg_data[gap_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	// effective bounds: zero counts as one, oversize saturates
	logic [CHN_W-1:0]  eff_chans;
	logic [AREA_W-1:0] eff_area;

	always_comb begin
		if (ch_count_q == '0) begin
			eff_chans = CHN_W'(1);
		end else if (32'(ch_count_q) > 32'(MAX_CHANNELS)) begin
			eff_chans = CHN_W'(MAX_CHANNELS);
		end else begin
			eff_chans = CHN_W'(ch_count_q);
		end
		if (area_q == '0) begin
			eff_area = AREA_W'(1);
		end else if (32'(area_q) > 32'(MAX_AREA)) begin
			eff_area = AREA_W'(MAX_AREA);
		end else begin
			eff_area = AREA_W'(area_q);
		end
	end

	// stage 0: accept, position tracking, memory read
	logic            en;
	logic            accept;
	logic            buf_full;
	logic [CH_W-1:0] ch_pos_q;
	logic [PX_W-1:0] px_pos_q;
	logic            first_pix;
	logic            last_pix;
	logic            last_chan;

	assign en        = !buf_full;
	assign in_stall  = buf_full;
	assign accept    = in_valid && !in_stall;
	assign first_pix = (px_pos_q == '0);
	assign last_pix  = (AREA_W'(px_pos_q) + AREA_W'(1)) >= eff_area;
	assign last_chan = (CHN_W'(ch_pos_q) + CHN_W'(1)) >= eff_chans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_pos_q <= '0;
			px_pos_q <= '0;
		end else if (accept) begin
			if (last_chan) begin
				ch_pos_q <= '0;
				px_pos_q <= last_pix ? '0 : px_pos_q + PX_W'(1);
			end else begin
				ch_pos_q <= ch_pos_q + CH_W'(1);
			end
		end
	end

	// stage 1: read data back, accumulate, write back
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          first_s1;
	logic                          last_pix_s1;
	logic                          last_chan_s1;
	logic [CH_W-1:0]               ch_s1;
	logic                          fwd_hit_s1;
	logic [SUM_W-1:0]              fwd_data_s1;
	logic [SUM_W-1:0]              rd_data_q;
	logic [SUM_W-1:0]              base_sum;
	logic [SUM_W-1:0]              sum_new;
	logic                          mem_we;

	logic [SUM_W-1:0] sums_mem [MAX_CHANNELS];

	assign mem_we   = en && valid_s1;
	// a write landing at the same edge as the read is not in the read data: take it here
	assign base_sum = fwd_hit_s1 ? fwd_data_s1 : rd_data_q;
	assign sum_new  = first_s1 ? SUM_W'(sample_s1) : base_sum + SUM_W'(sample_s1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sums_mem[ch_s1] <= sum_new;
		end
		if (accept) begin
			rd_data_q <= sums_mem[ch_pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1    <= sample;
			first_s1     <= first_pix;
			last_pix_s1  <= last_pix;
			last_chan_s1 <= last_chan;
			ch_s1        <= ch_pos_q;
			fwd_hit_s1   <= mem_we && (ch_s1 == ch_pos_q);
			fwd_data_s1  <= sum_new;
		end
	end

	// stage 2: completed sum times reciprocal
	logic                    valid_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic [CH_W-1:0]         ch_s2;
	logic                    last_chan_s2;

	// stage 3: product, then round and saturate into the output buffer
	logic                     valid_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic [CH_W-1:0]          ch_s3;
	logic                     last_chan_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			// only the last pixel of an image carries on past the write-back
			valid_s2 <= valid_s1 && last_pix_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2       <= sum_new;
			ch_s2        <= ch_s1;
			last_chan_s2 <= last_chan_s1;
			prod_s3      <= PROD_W'(sum_s2) * PROD_W'($signed({1'b0, recip_q}));
			ch_s3        <= ch_s2;
			last_chan_s3 <= last_chan_s2;
		end
	end

	logic [PROD_W-1:0]             rnd_full;
	logic signed [RND_W-1:0]       rnd;
	logic signed [SAMPLE_BITS-1:0] avg_sat;
	logic [31:0]                   ch_wide;
	logic [DATA_W-1:0]             push_data;
	logic [DATA_W-1:0]             out_data;

	always_comb begin
		// add half, then drop the fraction bits: a floor on the two's complement value
		rnd_full = prod_s3 + ROUND_HALF;
		rnd      = rnd_full[PROD_W-1:gap_pkg::ROUND_SHIFT];
		if (rnd > SAT_HI) begin
			avg_sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rnd < SAT_LO) begin
			avg_sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			avg_sat = rnd[SAMPLE_BITS-1:0];
		end
		ch_wide   = 32'(ch_s3);
		push_data = {avg_sat, ch_wide[gap_pkg::IDX_W-1:0], last_chan_s3};
	end

	gap_out_buf #(
		.DATA_W (DATA_W)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && valid_s3),
		.push_data (push_data),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign average       = out_data[DATA_W-1 -: SAMPLE_BITS];
	assign channel_index = out_data[gap_pkg::IDX_W:1];
	assign last_channel  = out_data[0];

endmodule

>>> src/gap_checker.sv
// Port-level checks for the pooling core, attached by bind.
// Depends on gap_pkg and the assertion macros header.
`include "global_average_pool_core_defines.svh"

module gap_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [SAMPLE_BITS-1:0]    sample,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [SAMPLE_BITS-1:0]    average,
	input logic [gap_pkg::IDX_W-1:0] channel_index,
	input logic                      last_channel
);

	// a stalled result holds
	`GAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(average) && $stable(channel_index) && $stable(last_channel))

	// a stalled input item holds
	`GAP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(sample))

	// input back-pressure only with a result waiting
	`GAP_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)

	// the buffer fills only behind a stalled result
	`GAP_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind global_average_pool_core gap_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_gap_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.sample        (sample),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.average       (average),
	.channel_index (channel_index),
	.last_channel  (last_channel)
);

>>> tb/global_average_pool_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for global_average_pool_core: directed table, then random images.
// Depends on gap_pkg and the core; holds its own per-channel sum predictor.
module global_average_pool_core_tb;

	localparam int MAX_CH       = 1024;
	localparam int MAX_PIX      = 65536;
	localparam int SAMPLE_HI    = 32767;
	localparam int SAMPLE_LO    = -32768;
	localparam int SETTLE       = 8;
	localparam int RANDOM_ITEMS = 1600;
	localparam logic [gap_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [15:0]               average;
		logic [gap_pkg::IDX_W-1:0] channel;
		logic                      last;
	} mean_t;

	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e                      kind;
		logic [gap_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [gap_pkg::CFG_DATA_W-1:0] value;
		bit                             typed;
		mean_t                          want;
	} row_t;

	localparam int SCRIPT_LEN = 41;
	row_t script [SCRIPT_LEN] = '{
		'{ROW_ITEM,  '0, 17'h07FFF, 1'b1, '{16'h7FFF, 10'd0, 1'b1}},
		'{ROW_ITEM,  '0, 17'h08000, 1'b1, '{16'h8000, 10'd0, 1'b1}},
		'{ROW_ITEM,  '0, 17'h00000, 1'b1, '{16'h0000, 10'd0, 1'b1}},
		'{ROW_ITEM,  '0, 17'h05555, 1'b1, '{16'h5555, 10'd0, 1'b1}},
		'{ROW_ITEM,  '0, 17'h0AAAA, 1'b1, '{16'hAAAA, 10'd0, 1'b1}},
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h00000, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h07FFF, 1'b1, '{16'h0000, 10'd0, 1'b1}},
		// reciprocal beyond one: results saturate
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h1FFFF, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h07FFF, 1'b1, '{16'h7FFF, 10'd0, 1'b1}},
		'{ROW_ITEM,  '0, 17'h08000, 1'b1, '{16'h8000, 10'd0, 1'b1}},
		'{ROW_ITEM,  '0, 17'h0FFFF, 1'b0, '0},
		// zero channel count acts as one
		'{ROW_WRITE, gap_pkg::REG_CHANNEL_COUNT, 17'h00000, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h10000, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h00005, 1'b1, '{16'h0005, 10'd0, 1'b1}},
		'{ROW_WRITE, gap_pkg::REG_CHANNEL_COUNT, 17'h00003, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_IMAGE_AREA, 17'h00002, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h08000, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h00064, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h0FFF9, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h07FFF, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h00003, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h0FFF8, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h07FFF, 1'b0, '0},
		'{ROW_WRITE, REG_UNUSED, 17'h1ABCD, 1'b0, '0},
		// oversized channel count and zero area clamp
		'{ROW_WRITE, gap_pkg::REG_CHANNEL_COUNT, 17'h1FFFF, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_IMAGE_AREA, 17'h00000, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h10000, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h00001, 1'b1, '{16'h0001, 10'd0, 1'b0}},
		'{ROW_ITEM,  '0, 17'h00002, 1'b1, '{16'h0002, 10'd1, 1'b0}},
		'{ROW_ITEM,  '0, 17'h00003, 1'b1, '{16'h0003, 10'd2, 1'b0}},
		// shrink mid-image: channel 3 is beyond the new bound, so it ends the pixel
		'{ROW_WRITE, gap_pkg::REG_CHANNEL_COUNT, 17'h00002, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h00009, 1'b1, '{16'h0009, 10'd3, 1'b1}},
		'{ROW_WRITE, gap_pkg::REG_CHANNEL_COUNT, 17'h00001, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_IMAGE_AREA, 17'h1FFFF, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h00001, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h003E8, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h007D0, 1'b0, '0},
		// pixel position beyond the new area: this pixel is the last
		'{ROW_WRITE, gap_pkg::REG_IMAGE_AREA, 17'h00002, 1'b0, '0},
		'{ROW_ITEM,  '0, 17'h00BB8, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_IMAGE_AREA, 17'h00001, 1'b0, '0},
		'{ROW_WRITE, gap_pkg::REG_AREA_RECIPROCAL, 17'h10000, 1'b0, '0}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [gap_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [gap_pkg::CFG_DATA_W-1:0]   cfg_data;
	logic                             in_valid;
	logic                             in_stall;
	logic signed [15:0]               sample;
	logic                             out_valid;
	logic                             out_stall;
	logic signed [15:0]               average;
	logic [gap_pkg::IDX_W-1:0]        channel_index;
	logic                             last_channel;

	// predictor state
	logic [gap_pkg::SUM_W-1:0]        acc_sums [MAX_CH];
	bit                               sum_written [MAX_CH];
	int                               chan_pos;
	int                               pixel_pos;
	logic [gap_pkg::CH_COUNT_W-1:0]   reg_channels;
	logic [gap_pkg::AREA_CFG_W-1:0]   reg_area;
	logic [gap_pkg::RECIP_W-1:0]      reg_recip;

	mean_t                            pending_means [$];
	int                               mismatches;
	bit                               calm;
	int                               out_hold;

	global_average_pool_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.average       (average),
		.channel_index (channel_index),
		.last_channel  (last_channel)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clamp_count(input int v, input int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bit sums_ready(input int n);
		for (int i = 0; i < n; i++)
			if (!sum_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Fold one sample into its channel sum; at the last pixel produce the rounded mean.
	function automatic bit accumulate_sample(input logic signed [15:0] s, output mean_t m);
		int      chans;
		int      area;
		int      c;
		bit      last_pix;
		bit      last_ch;
		longint  prod;
		longint  avg;
		chans = clamp_count(int'(reg_channels), MAX_CH);
		area  = clamp_count(int'(reg_area), MAX_PIX);
		c     = (chan_pos >= MAX_CH) ? MAX_CH - 1 : chan_pos;
		m     = '0;
		if (pixel_pos == 0)
			acc_sums[c] = {{16{s[15]}}, s};
		else
			acc_sums[c] = acc_sums[c] + {{16{s[15]}}, s};
		sum_written[c] = 1'b1;
		last_pix = (pixel_pos + 1) >= area;
		last_ch  = (chan_pos + 1) >= chans;
		if (last_pix) begin
			prod = longint'($signed(acc_sums[c])) * longint'(reg_recip);
			avg  = (prod + 32768) >>> gap_pkg::ROUND_SHIFT;
			if (avg > SAMPLE_HI)
				avg = SAMPLE_HI;
			if (avg < SAMPLE_LO)
				avg = SAMPLE_LO;
			m.average = avg[15:0];
			m.channel = chan_pos[gap_pkg::IDX_W-1:0];
			m.last    = last_ch;
		end
		if (last_ch) begin
			chan_pos  = 0;
			pixel_pos = last_pix ? 0 : pixel_pos + 1;
		end else begin
			chan_pos = chan_pos + 1;
		end
		return last_pix;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return 16'($urandom_range(0, 128)) - 16'd64;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Write one register once the core has drained.
	task automatic write_register(input logic [gap_pkg::CFG_IDX_W-1:0] idx,
			input logic [gap_pkg::CFG_DATA_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gap_pkg::REG_CHANNEL_COUNT:   reg_channels = value[gap_pkg::CH_COUNT_W-1:0];
			gap_pkg::REG_IMAGE_AREA:      reg_area     = value[gap_pkg::AREA_CFG_W-1:0];
			gap_pkg::REG_AREA_RECIPROCAL: reg_recip    = value[gap_pkg::RECIP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_sample(input logic signed [15:0] s, input bit use_typed,
			input mean_t typed_mean);
		mean_t m;
		in_valid <= 1'b1;
		sample   <= s;
		do
			@(posedge clk);
		while (in_stall);
		if (accumulate_sample(s, m))
			pending_means.push_back(use_typed ? typed_mean : m);
		if (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Mid-image change: never grow the channel count over sums not yet written.
	task automatic reshape_image();
		int cand;
		if ($urandom_range(0, 1) == 1) begin
			if (clamp_count(int'(reg_channels), MAX_CH) > 64)
				cand = $urandom_range(1, 2);
			else
				cand = $urandom_range(0, 12);
			if (pixel_pos == 0 || sums_ready(clamp_count(cand, MAX_CH)))
				write_register(gap_pkg::REG_CHANNEL_COUNT, gap_pkg::CFG_DATA_W'(cand));
		end
		if ($urandom_range(0, 1) == 1)
			write_register(gap_pkg::REG_AREA_RECIPROCAL,
				gap_pkg::CFG_DATA_W'($urandom_range(0, 131071)));
		write_register(gap_pkg::REG_IMAGE_AREA, gap_pkg::CFG_DATA_W'($urandom_range(0, 4)));
	endtask

	always @(posedge clk) begin : watch
		mean_t m;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_means.size() == 0) begin
					flag_mismatch($sformatf("unexpected result ch %0d", channel_index));
				end else begin
					m = pending_means.pop_front();
					if (average !== m.average)
						flag_mismatch($sformatf("ch %0d average %0d, want %0d",
							m.channel, average, $signed(m.average)));
					if (channel_index !== m.channel)
						flag_mismatch($sformatf("channel_index %0d, want %0d",
							channel_index, m.channel));
					if (last_channel !== m.last)
						flag_mismatch($sformatf("ch %0d last_channel %b, want %b",
							m.channel, last_channel, m.last));
				end
			end
			if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 8) begin
				out_hold = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#10ms;
		$display("global_average_pool_core_tb failed");
		$finish;
	end

	initial begin
		int sent;
		int fed;
		int total;
		int mid_at;
		int cc_v;
		int area_v;
		int r;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sample       = '0;
		out_stall    = 1'b0;
		out_hold     = 0;
		calm         = 1'b0;
		mismatches   = 0;
		chan_pos     = 0;
		pixel_pos    = 0;
		reg_channels = gap_pkg::CH_COUNT_RST;
		reg_area     = gap_pkg::AREA_RST;
		reg_recip    = gap_pkg::RECIP_RST;
		foreach (sum_written[i])
			sum_written[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE)
				write_register(script[i].reg_idx, script[i].value);
			else
				push_sample(script[i].value[15:0], script[i].typed, script[i].want);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				cc_v = 0;
			else if (r < 6)
				cc_v = $urandom_range(1024, 2047);
			else if (r < 20)
				cc_v = $urandom_range(9, 64);
			else
				cc_v = $urandom_range(1, 8);
			r = $urandom_range(0, 99);
			if (clamp_count(cc_v, MAX_CH) > 64)
				area_v = $urandom_range(1, 2);
			else if (r < 4)
				area_v = 0;
			else if (r < 8)
				area_v = $urandom_range(60000, 131071);
			else
				area_v = $urandom_range(1, 8);
			write_register(gap_pkg::REG_CHANNEL_COUNT, gap_pkg::CFG_DATA_W'(cc_v));
			write_register(gap_pkg::REG_IMAGE_AREA, gap_pkg::CFG_DATA_W'(area_v));
			r = $urandom_range(0, 99);
			if (r < 10)
				write_register(gap_pkg::REG_AREA_RECIPROCAL,
					gap_pkg::CFG_DATA_W'($urandom_range(0, 131071)));
			else if (r < 15)
				write_register(gap_pkg::REG_AREA_RECIPROCAL, gap_pkg::RECIP_RST);
			else
				write_register(gap_pkg::REG_AREA_RECIPROCAL, gap_pkg::CFG_DATA_W'(
					(MAX_PIX + clamp_count(area_v, MAX_PIX) / 2) / clamp_count(area_v, MAX_PIX)));

			total = clamp_count(cc_v, MAX_CH) * clamp_count(area_v, MAX_PIX)
				* $urandom_range(1, 3);
			mid_at = 0;
			if (total > 3000)
				mid_at = $urandom_range(1, 20);
			else if (total > 1 && $urandom_range(0, 3) == 0)
				mid_at = $urandom_range(1, total - 1);

			fed = 0;
			do begin
				if (mid_at != 0 && fed == mid_at)
					reshape_image();
				calm = (sent >= 600 && sent < 900);
				push_sample(pick_sample(), 1'b0, '0);
				fed++;
				sent++;
			end while (!(chan_pos == 0 && pixel_pos == 0
				&& (fed >= total || (mid_at != 0 && fed > mid_at))));
		end

		in_valid <= 1'b0;
		calm = 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("global_average_pool_core_tb passed");
		else
			$display("global_average_pool_core_tb failed");
		$finish;
	end

endmodule
